[rtl/amt_pkg.sv]
// Shared types and constants of the alarm match table.
`default_nettype none

package amt_pkg;

    // Field widths of the command and result transfers
    localparam int TIME_W   = 12;
    localparam int TONE_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int KIND_W   = 2;
    localparam int REM_W    = 5;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_REJ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RING     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NO_MATCH = 2'd3;

    // Time coding: hour * HOUR_SCALE + minute, valid below TIME_LIMIT
    localparam logic [TIME_W-1:0] TIME_LIMIT = 12'd2400;
    localparam logic [TIME_W-1:0] HOUR_SCALE = 12'd100;

    typedef struct packed {
        logic                opcode;
        logic [TIME_W-1:0]   wake_time;
        logic [TONE_W-1:0]   tone;
        logic [HOUR_W-1:0]   now_hour;
        logic [MINUTE_W-1:0] now_minute;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TONE_W-1:0] ring_tone;
        logic [REM_W-1:0]  remaining;
        logic              last;
    } t_result;

    // One stored alarm
    typedef struct packed {
        logic [TIME_W-1:0] wake_time;
        logic [TONE_W-1:0] tone;
    } t_entry;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/alarm_match_table.sv]
// Top level of the alarm match table: slot chain, scan sequencer and result register.
`default_nettype none

// One-shot alarm table of ALARM_SLOTS entries kept in stored order in a chain
// of slot cells. On an add (opcode 0) busy stays low and the next command may
// follow in the next cycle. A check (opcode 1) on a table of N alarms keeps
// busy high after the transfer until the scan and its final result are done:
// the chain rotates one slot per cycle through its head, where each entry is
// compared against the current time, matched entries are dropped and the others
// are reinserted at the tail, so the order is kept. A check on an empty table leaves busy low.
// Each result is held on o_result for one cycle with o_strobe high; the
// receiver cannot stall it. Results are registered; the final result of each
// command carries last.
module alarm_match_table #(
    parameter int ALARM_SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire amt_pkg::t_cmd    i_cmd,
    output      logic             busy,
    output      logic             o_strobe,
    output      amt_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(ALARM_SLOTS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [CNT_W-1:0]                r_left, n_left;
    logic [amt_pkg::TIME_W-1:0]      r_key, n_key;
    logic                            r_pend_valid, n_pend_valid;
    logic [amt_pkg::TONE_W-1:0]      r_pend_tone, n_pend_tone;
    logic [amt_pkg::REM_W-1:0]       r_pend_rem, n_pend_rem;
    logic                            r_strobe, n_strobe;
    amt_pkg::t_result                r_result, n_result;

    logic                            w_accept;
    logic                            w_match;
    logic                            w_shift;
    logic                            w_load_en;
    logic [IDX_W-1:0]                w_load_idx;
    amt_pkg::t_entry                 w_load_entry;
    amt_pkg::t_entry                 w_entry [ALARM_SLOTS];

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);

    // Compare the chain head against the time key of the running check
    assign w_match = (w_entry[0].wake_time == r_key);

    // Slot chain: each cell takes its right neighbor, the last takes the load entry
    for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_cell
        amt_pkg::t_cell_ctl w_ctl;
        amt_pkg::t_entry    w_next;

        assign w_ctl.shift = w_shift;
        assign w_ctl.load  = w_load_en && (w_load_idx == IDX_W'(g));

        if (g == ALARM_SLOTS - 1) begin : g_tail
            assign w_next = w_load_entry;
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        amt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_load_entry (w_load_entry),
            .i_next_entry (w_next),
            .o_entry      (w_entry[g])
        );
    end

    // Sequence adds and check scans
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_key        = r_key;
        n_pend_valid = r_pend_valid;
        n_pend_tone  = r_pend_tone;
        n_pend_rem   = r_pend_rem;
        n_strobe     = 1'b0;
        n_result     = r_result;
        w_shift      = 1'b0;
        w_load_en    = 1'b0;
        w_load_idx   = IDX_W'(r_count);
        w_load_entry = w_entry[0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.opcode == amt_pkg::OP_ADD) begin
                        w_load_entry.wake_time = i_cmd.wake_time;
                        w_load_entry.tone      = i_cmd.tone;
                        n_strobe               = 1'b1;
                        n_result.ring_tone     = '0;
                        n_result.last          = 1'b1;
                        if (i_cmd.wake_time >= amt_pkg::TIME_LIMIT
                                || r_count >= SLOTS_CNT) begin
                            n_result.kind      = amt_pkg::KIND_ADD_REJ;
                            n_result.remaining = (amt_pkg::REM_W)'(r_count);
                        end else begin
                            w_load_en          = 1'b1;
                            n_count            = r_count + CNT_ONE;
                            n_result.kind      = amt_pkg::KIND_ADD_OK;
                            n_result.remaining = (amt_pkg::REM_W)'(r_count + CNT_ONE);
                        end
                    end else begin
                        n_key = amt_pkg::TIME_W'(i_cmd.now_hour) * amt_pkg::HOUR_SCALE
                              + amt_pkg::TIME_W'(i_cmd.now_minute);
                        n_pend_valid = 1'b0;
                        if (r_count == '0) begin
                            n_strobe           = 1'b1;
                            n_result.kind      = amt_pkg::KIND_NO_MATCH;
                            n_result.ring_tone = '0;
                            n_result.remaining = '0;
                            n_result.last      = 1'b1;
                        end else begin
                            n_left  = r_count;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN: begin
                // Pop the head; reinsert it at the tail unless it rings
                w_shift    = 1'b1;
                w_load_idx = IDX_W'(r_count - CNT_ONE);
                if (w_match) begin
                    n_count = r_count - CNT_ONE;
                    if (r_pend_valid) begin
                        n_strobe           = 1'b1;
                        n_result.kind      = amt_pkg::KIND_RING;
                        n_result.ring_tone = r_pend_tone;
                        n_result.remaining = r_pend_rem;
                        n_result.last      = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_tone  = w_entry[0].tone;
                    n_pend_rem   = (amt_pkg::REM_W)'(r_count - CNT_ONE);
                end else begin
                    w_load_en = 1'b1;
                end
                n_left = r_left - CNT_ONE;
                if (r_left == CNT_ONE) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                // Flush the held ring as the final result, or report no match
                n_strobe      = 1'b1;
                n_result.last = 1'b1;
                if (r_pend_valid) begin
                    n_result.kind      = amt_pkg::KIND_RING;
                    n_result.ring_tone = r_pend_tone;
                    n_result.remaining = r_pend_rem;
                end else begin
                    n_result.kind      = amt_pkg::KIND_NO_MATCH;
                    n_result.ring_tone = '0;
                    n_result.remaining = (amt_pkg::REM_W)'(r_count);
                end
                n_pend_valid = 1'b0;
                n_state      = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_left       <= n_left;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_pend_tone <= n_pend_tone;
        r_pend_rem  <= n_pend_rem;
        r_result    <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The table never holds more than its slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_CNT)
        else $error("alarm count exceeds slot count");

    // A scan only removes entries
    a_scan_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |=> r_count <= $past(r_count))
        else $error("alarm count grew during a scan");

    // A final result leaves the block ready for the next command
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> r_state == ST_IDLE)
        else $error("final result while a scan is still running");

    // A non-final result only comes out of a running check
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> r_state != ST_IDLE
            && o_result.kind == amt_pkg::KIND_RING)
        else $error("non-final result outside a scan");

endmodule

`default_nettype wire

[rtl/amt_cell.sv]
// One slot of the alarm chain: holds an entry, loads it or takes its neighbor's.
`default_nettype none

module amt_cell (
    input  wire logic               i_clk,
    input  wire amt_pkg::t_cell_ctl i_ctl,
    input  wire amt_pkg::t_entry    i_load_entry,
    input  wire amt_pkg::t_entry    i_next_entry,
    output      amt_pkg::t_entry    o_entry
);

    amt_pkg::t_entry r_entry;
    amt_pkg::t_entry n_entry;

    // Load wins over the shift from the neighbor
    always_comb begin
        priority if (i_ctl.load) begin
            n_entry = i_load_entry;
        end else if (i_ctl.shift) begin
            n_entry = i_next_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
